/* rtl/core/dgf_pkg.sv */
// ----------------------------------------------------------------------------
// dgf_pkg
// Types and constants shared by the diagonal Gaussian fusion block.
// ----------------------------------------------------------------------------
package dgf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_W    = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // pi with 48 fraction bits, rounded to FRAC_BITS fraction bits
    localparam longint unsigned PI_Q48  = 64'h3243F6A8885A3;
    localparam int              ASHIFT  = 48 - FRAC_BITS;
    localparam longint unsigned ARND    = 64'd1 << (ASHIFT - 1);
    localparam longint unsigned HALF_PI_L  = (PI_Q48 / 2 + ARND) >> ASHIFT;
    localparam longint unsigned THREE_HP_L = (PI_Q48 * 3 / 2 + ARND) >> ASHIFT;
    localparam longint unsigned TWO_PI_L   = (PI_Q48 * 2 + ARND) >> ASHIFT;
    localparam logic signed [32:0] HALF_PI     = 33'(HALF_PI_L);
    localparam logic signed [32:0] THREE_HALF_PI = 33'(THREE_HP_L);
    localparam logic signed [32:0] TWO_PI      = 33'(TWO_PI_L);

    // quotient bits of both dividers (offset magnitude fits 33 bits)
    localparam int DIV_BITS = 33;
    // start to done, in cycles
    localparam int LATENCY  = DIV_BITS + 4;

    typedef struct packed {
        logic                is_heading;
        logic                null_a;
        logic                null_b;
        logic signed [31:0]  mean_a;
        logic [31:0]         var_a;
        logic [WEIGHT_W-1:0] weight_a;
        logic signed [31:0]  mean_b;
        logic [31:0]         var_b;
        logic [WEIGHT_W-1:0] weight_b;
    } in_t;

    typedef struct packed {
        logic                null_out;
        logic signed [31:0]  mean_out;
        logic [31:0]         var_out;
        logic [WEIGHT_W-1:0] weight_out;
        logic                div_error;
    } out_t;

endpackage

/* rtl/core/diagonal_gaussian_fusion_top.sv */
// ----------------------------------------------------------------------------
// diagonal_gaussian_fusion_top
// Fuses two 1-D Gaussian estimates per beat, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; a beat is taken on every edge
//   with start high and busy low. busy is always low, so one axis can be fed
//   every cycle (one beat per cycle sustained).
//   Output channel: result is valid for exactly one cycle while done is high.
//   The receiver cannot stall; results leave in input order.
//   Pipeline: the two restoring dividers, one quotient bit per stage, run
//   side by side: stage 1 registers the beat, stage 2 applies the heading
//   correction and forms the sum, stage 3 forms the two products, then 33
//   divider stages, then the output register.
//   Reset clears all valid bits at once; beats in flight are dropped and no
//   spurious done is produced. There is no configuration and no state.
// ----------------------------------------------------------------------------
module diagonal_gaussian_fusion_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  dgf_pkg::in_t  item,
    output logic          done,
    output dgf_pkg::out_t result
);
    import dgf_pkg::*;

    typedef struct packed {
        logic               special;   // result already known in pre
        out_t               pre;
        logic signed [32:0] ma;        // corrected first mean
        logic               neg;       // sign of mb - ma
        logic [32:0]        sum;
    } side_t;

    typedef struct packed {
        logic [32:0] r;
        logic [32:0] lo;               // remaining dividend bits, then quotient
    } lane_t;

    typedef struct packed {
        side_t side;
        lane_t lv;                     // variance divider
        lane_t lm;                     // mean offset divider
    } dstage_t;

    function automatic lane_t div_step(lane_t l, logic [32:0] s);
        logic [33:0] t;
        logic        ge;
        lane_t       n;
        t      = {l.r, l.lo[32]};
        ge     = (t >= {1'b0, s});
        n.r    = ge ? 33'(t - {1'b0, s}) : t[32:0];
        n.lo   = {l.lo[31:0], ge};
        return n;
    endfunction

    assign busy = 1'b0;

    // stage 1: capture
    logic s1_v_reg;
    in_t  s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_reg <= item;
        end
    end

    // stage 2: special cases, heading correction, difference, sum, weight
    logic signed [32:0] ma_c;
    logic signed [32:0] mb_c;
    logic signed [33:0] diff;
    logic [33:0]        mag_w;
    logic [33:0]        wprod;
    logic [WEIGHT_W-1:0] wsat;
    side_t              side_next;

    always_comb
    begin
        ma_c = 33'(s1_reg.mean_a);
        mb_c = 33'(s1_reg.mean_b);
        if (s1_reg.is_heading)
        begin
            if (ma_c < HALF_PI && mb_c > THREE_HALF_PI)
            begin
                mb_c = mb_c - TWO_PI;
            end
            else if (mb_c < HALF_PI && ma_c > THREE_HALF_PI)
            begin
                ma_c = ma_c - TWO_PI;
            end
        end
        diff  = 34'(mb_c) - 34'(ma_c);
        mag_w = diff[33] ? 34'(-diff) : 34'(diff);

        wprod = 34'(s1_reg.weight_a) * 34'(s1_reg.weight_b);
        wsat  = (wprod[33:WEIGHT_FRAC] > 18'(WEIGHT_ONE))
              ? WEIGHT_ONE : wprod[WEIGHT_FRAC +: WEIGHT_W];

        side_next.ma  = ma_c;
        side_next.neg = diff[33];
        side_next.sum = 33'(s1_reg.var_a) + 33'(s1_reg.var_b);
        side_next.special = 1'b1;
        side_next.pre = '0;
        if (s1_reg.null_a && s1_reg.null_b)
        begin
            side_next.pre.null_out = 1'b1;
        end
        else if (s1_reg.null_b)
        begin
            side_next.pre.mean_out   = s1_reg.mean_a;
            side_next.pre.var_out    = s1_reg.var_a;
            side_next.pre.weight_out = s1_reg.weight_a;
        end
        else if (s1_reg.null_a)
        begin
            side_next.pre.mean_out   = s1_reg.mean_b;
            side_next.pre.var_out    = s1_reg.var_b;
            side_next.pre.weight_out = s1_reg.weight_b;
        end
        else
        begin
            side_next.pre.weight_out = wsat;
            side_next.pre.div_error  = (side_next.sum == '0);
            side_next.special        = side_next.pre.div_error;
        end
    end

    logic        s2_v_reg;
    side_t       s2_side_reg;
    logic [31:0] s2_va_reg;
    logic [31:0] s2_vb_reg;
    logic [32:0] s2_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= side_next;
        s2_va_reg   <= s1_reg.var_a;
        s2_vb_reg   <= s1_reg.var_b;
        s2_mag_reg  <= mag_w[32:0];
    end

    // stage 3: products, divider setup
    logic [63:0] pv;
    logic [64:0] pm;
    dstage_t     d0_next;

    always_comb
    begin
        pv = 64'(s2_va_reg) * 64'(s2_vb_reg);
        pm = 65'(s2_va_reg) * 65'(s2_mag_reg);
        d0_next.side  = s2_side_reg;
        d0_next.lv.r  = {2'b00, pv[63:DIV_BITS]};
        d0_next.lv.lo = pv[DIV_BITS-1:0];
        d0_next.lm.r  = {1'b0, pm[64:DIV_BITS]};
        d0_next.lm.lo = pm[DIV_BITS-1:0];
    end

    // divider stages: index 0 is setup, 1..DIV_BITS one quotient bit each
    logic    dv_v_reg [0:DIV_BITS];
    dstage_t dv_reg   [0:DIV_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_BITS; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_v_reg[0] <= s2_v_reg;
            for (int i = 1; i <= DIV_BITS; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= d0_next;
        for (int i = 1; i <= DIV_BITS; i++)
        begin
            dv_reg[i].side <= dv_reg[i-1].side;
            dv_reg[i].lv   <= div_step(dv_reg[i-1].lv, dv_reg[i-1].side.sum);
            dv_reg[i].lm   <= div_step(dv_reg[i-1].lm, dv_reg[i-1].side.sum);
        end
    end

    // output: apply offset from the first mean toward the second
    dstage_t            dl;
    logic signed [33:0] mean_w;
    out_t               result_next;

    always_comb
    begin
        dl     = dv_reg[DIV_BITS];
        mean_w = dl.side.neg ? 34'(dl.side.ma) - 34'(dl.lm.lo)
                             : 34'(dl.side.ma) + 34'(dl.lm.lo);
        if (dl.side.special)
        begin
            result_next = dl.side.pre;
        end
        else
        begin
            result_next            = dl.side.pre;
            result_next.mean_out   = mean_w[31:0];
            result_next.var_out    = dl.lv.lo[31:0];
        end
    end

    logic done_reg;
    out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v_reg[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result did not appear after pipeline latency");

    a_null: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.null_out |-> !result.div_error && result.weight_out == '0)
        else $error("null result carries data");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.div_error |-> result.var_out == '0 && result.mean_out == '0)
        else $error("division error with nonzero mean or variance");

endmodule
